### hdl/srtl_pkg.sv
// ----------------------------------------------------------------------------
// srtl_pkg
// Shared types and constants for the sorted region table lookup unit.
// ----------------------------------------------------------------------------
package srtl_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int SEGS_PER_ENTRY_DEF = 16;

   localparam logic [1:0] FUNC_ADD_SEG = 2'd0;
   localparam logic [1:0] FUNC_COMMIT  = 2'd1;
   localparam logic [1:0] FUNC_LK_ADDR = 2'd2;
   localparam logic [1:0] FUNC_LK_KEY  = 2'd3;

   localparam logic [2:0] ST_NOTED   = 3'd0;
   localparam logic [2:0] ST_INSERT  = 3'd1;
   localparam logic [2:0] ST_DUP     = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;
   localparam logic [2:0] ST_HIT     = 3'd5;
   localparam logic [2:0] ST_MISS    = 3'd6;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] address;
      logic [63:0] seg_end;
      logic        is_text;
      logic        file_backed;
      logic [63:0] key;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] payload_out;
      logic [7:0]  index_out;
   } rsp_type;

   // datapath operations issued by the controller
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;  // latch request
   localparam logic [3:0] OP_SEG       = 4'd2;  // pending segment update
   localparam logic [3:0] OP_CLR_PEND  = 4'd3;
   localparam logic [3:0] OP_RD_IDX    = 4'd4;  // read entry at idx
   localparam logic [3:0] OP_IDX_INC   = 4'd5;
   localparam logic [3:0] OP_MOVE_RD   = 4'd6;  // read entry/seg idx-1
   localparam logic [3:0] OP_MOVE_WR   = 4'd7;  // write to idx
   localparam logic [3:0] OP_INS_WR    = 4'd8;  // write pending seg sub to idx
   localparam logic [3:0] OP_BS_MID    = 4'd9;
   localparam logic [3:0] OP_BS_UPD    = 4'd10;
   localparam logic [3:0] OP_SEG_RD    = 4'd11;
   localparam logic [3:0] OP_SET_RSP   = 4'd12;
   localparam logic [3:0] OP_INS_DONE  = 4'd13;
   localparam logic [3:0] OP_IDX_DEC   = 4'd14;
   localparam logic [3:0] OP_SUB_INC   = 4'd15;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] status;   // for OP_SET_RSP
      logic       use_pay;  // response carries entry payload
      logic       sub_clr;
      logic       idx_clr;
      logic       idx_from_cnt;
      logic       idx_from_lo;
   } cmd_type;

   typedef struct packed {
      logic func_add;
      logic func_commit;
      logic func_lk_addr;
      logic pend_bad;
      logic full;
      logic idx_at_cnt;     // idx == entry_count
      logic idx_zero;
      logic key_eq;
      logic start_lt_min;   // start of the entry last read < pend_min
      logic bs_done;
      logic span_hit;
      logic sub_last;       // sub == stored seg count - 1 or beyond
      logic sub_end;        // sub == SEGS_PER_ENTRY - 1
      logic seg_hit;
      logic seg_none;       // entry has no stored segment
   } sts_type;

endpackage

### hdl/srtl_datapath.sv
// ----------------------------------------------------------------------------
// srtl_datapath
// Entry and segment memories, pending entry, indices and compare logic.
// ----------------------------------------------------------------------------
module srtl_datapath import srtl_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int SEGS_PER_ENTRY = SEGS_PER_ENTRY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = (SEGS_PER_ENTRY > 1) ? $clog2(SEGS_PER_ENTRY) : 1;
   localparam int NW = $clog2(SEGS_PER_ENTRY + 1);
   localparam int MW = IW + SW;

   logic [63:0] mem_start [TABLE_DEPTH];
   logic [63:0] mem_end   [TABLE_DEPTH];
   logic [63:0] mem_key   [TABLE_DEPTH];
   logic [31:0] mem_pay   [TABLE_DEPTH];
   logic [NW-1:0] mem_cnt [TABLE_DEPTH];
   logic [63:0] mem_lo    [TABLE_DEPTH*SEGS_PER_ENTRY];
   logic [63:0] mem_hi    [TABLE_DEPTH*SEGS_PER_ENTRY];
   logic [63:0] pend_lo   [SEGS_PER_ENTRY];
   logic [63:0] pend_hi   [SEGS_PER_ENTRY];

   req_type     req_ff;
   logic [CW-1:0] count_ff;
   logic [63:0] pmin_ff, pmax_ff;
   logic [NW-1:0] pcnt_ff;
   logic        ptext_ff;
   logic [CW-1:0] idx_ff, lo_ff, hi_ff, mid_ff;
   logic [SW-1:0] sub_ff;
   logic [63:0] rd_start_ff, rd_end_ff, rd_key_ff;
   logic [31:0] rd_pay_ff;
   logic [NW-1:0] rd_cnt_ff;
   logic [63:0] rd_lo_ff, rd_hi_ff;
   rsp_type     rsp_ff;

   logic [IW-1:0] idx_a, idx_m1;
   logic [MW-1:0] seg_a, seg_m1;
   logic [CW-1:0] mid_in;
   logic          seg_ok;

   assign idx_a  = idx_ff[IW-1:0];
   assign idx_m1 = IW'(idx_ff - CW'(1));
   assign mid_in = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign seg_a  = MW'(idx_a) * MW'(SEGS_PER_ENTRY) + MW'(sub_ff);
   assign seg_m1 = MW'(idx_m1) * MW'(SEGS_PER_ENTRY) + MW'(sub_ff);
   assign seg_ok = req_ff.file_backed && (req_ff.seg_end > req_ff.address);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pmin_ff  <= '1;
         pmax_ff  <= '0;
         pcnt_ff  <= '0;
         ptext_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_SEG: begin
               if (req_ff.is_text) ptext_ff <= 1'b1;
               if (seg_ok) begin
                  if (req_ff.address < pmin_ff) pmin_ff <= req_ff.address;
                  if (req_ff.seg_end > pmax_ff) pmax_ff <= req_ff.seg_end;
                  if (pcnt_ff < NW'(SEGS_PER_ENTRY)) pcnt_ff <= pcnt_ff + NW'(1);
               end
            end
            OP_CLR_PEND: begin
               pmin_ff  <= '1;
               pmax_ff  <= '0;
               pcnt_ff  <= '0;
               ptext_ff <= 1'b0;
            end
            OP_INS_DONE: count_ff <= count_ff + CW'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) req_ff <= req;
      if (cmd.op == OP_SEG && seg_ok && pcnt_ff < NW'(SEGS_PER_ENTRY)) begin
         pend_lo[pcnt_ff[SW-1:0]] <= req_ff.address;
         pend_hi[pcnt_ff[SW-1:0]] <= req_ff.seg_end;
      end
      if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_from_cnt) idx_ff <= count_ff;
      else if (cmd.idx_from_lo) idx_ff <= lo_ff;
      else if (cmd.op == OP_IDX_INC) idx_ff <= idx_ff + CW'(1);
      else if (cmd.op == OP_IDX_DEC) idx_ff <= idx_ff - CW'(1);
      if (cmd.sub_clr) sub_ff <= '0;
      else if (cmd.op == OP_SUB_INC || cmd.op == OP_MOVE_WR || cmd.op == OP_INS_WR)
         sub_ff <= sub_ff + SW'(1);
      case (cmd.op)
         OP_LOAD: begin
            lo_ff <= '0;
            hi_ff <= count_ff;
         end
         OP_BS_MID: mid_ff <= mid_in;
         OP_BS_UPD: begin
            if (rd_start_ff <= req_ff.address) lo_ff <= mid_ff + CW'(1);
            else hi_ff <= mid_ff;
         end
         default: ;
      endcase
      // entry memories: one read and one write port each
      case (cmd.op)
         OP_RD_IDX: begin
            rd_start_ff <= mem_start[idx_a];
            rd_end_ff   <= mem_end[idx_a];
            rd_key_ff   <= mem_key[idx_a];
            rd_pay_ff   <= mem_pay[idx_a];
            rd_cnt_ff   <= mem_cnt[idx_a];
         end
         OP_BS_MID: rd_start_ff <= mem_start[IW'(mid_in)];
         OP_MOVE_RD: begin
            rd_start_ff <= mem_start[idx_m1];
            rd_end_ff   <= mem_end[idx_m1];
            rd_key_ff   <= mem_key[idx_m1];
            rd_pay_ff   <= mem_pay[idx_m1];
            rd_cnt_ff   <= mem_cnt[idx_m1];
            rd_lo_ff    <= mem_lo[seg_m1];
            rd_hi_ff    <= mem_hi[seg_m1];
         end
         OP_SEG_RD: begin
            rd_lo_ff <= mem_lo[seg_a];
            rd_hi_ff <= mem_hi[seg_a];
         end
         default: ;
      endcase
      if (cmd.op == OP_MOVE_WR) begin
         if (sub_ff == '0) begin
            mem_start[idx_a] <= rd_start_ff;
            mem_end[idx_a]   <= rd_end_ff;
            mem_key[idx_a]   <= rd_key_ff;
            mem_pay[idx_a]   <= rd_pay_ff;
            mem_cnt[idx_a]   <= rd_cnt_ff;
         end
         mem_lo[seg_a] <= rd_lo_ff;
         mem_hi[seg_a] <= rd_hi_ff;
      end
      if (cmd.op == OP_INS_WR) begin
         if (sub_ff == '0) begin
            mem_start[idx_a] <= pmin_ff;
            mem_end[idx_a]   <= pmax_ff;
            mem_key[idx_a]   <= req_ff.key;
            mem_pay[idx_a]   <= req_ff.payload;
            mem_cnt[idx_a]   <= pcnt_ff;
         end
         mem_lo[seg_a] <= pend_lo[sub_ff];
         mem_hi[seg_a] <= pend_hi[sub_ff];
      end
      if (cmd.op == OP_SET_RSP) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.payload_out <= cmd.use_pay ? rd_pay_ff : '0;
         rsp_ff.index_out   <= (cmd.status == ST_NOTED || cmd.status == ST_INVALID ||
                                cmd.status == ST_FULL || cmd.status == ST_MISS)
                               ? 8'd0 : 8'(idx_ff);
      end
   end

   assign rsp = rsp_ff;

   always_comb begin
      sts.func_add     = (req_ff.func == FUNC_ADD_SEG);
      sts.func_commit  = (req_ff.func == FUNC_COMMIT);
      sts.func_lk_addr = (req_ff.func == FUNC_LK_ADDR);
      sts.pend_bad     = !ptext_ff || (pcnt_ff == '0);
      sts.full         = (count_ff >= CW'(TABLE_DEPTH));
      sts.idx_at_cnt   = (idx_ff == count_ff);
      sts.idx_zero     = (idx_ff == '0);
      sts.key_eq       = (rd_key_ff == req_ff.key);
      sts.start_lt_min = (rd_start_ff < pmin_ff);
      sts.bs_done      = !(lo_ff < hi_ff);
      sts.span_hit     = (req_ff.address >= rd_start_ff) && (req_ff.address < rd_end_ff);
      sts.sub_last     = (NW'(sub_ff) + NW'(1) >= rd_cnt_ff);
      sts.sub_end      = (sub_ff == SW'(SEGS_PER_ENTRY - 1));
      sts.seg_hit      = (req_ff.address >= rd_lo_ff) && (req_ff.address < rd_hi_ff);
      sts.seg_none     = (rd_cnt_ff == '0);
   end

endmodule

### hdl/srtl_ctrl.sv
// ----------------------------------------------------------------------------
// srtl_ctrl
// Sequencer for segment, commit, address lookup and key lookup requests.
// ----------------------------------------------------------------------------
module srtl_ctrl import srtl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DISP    = 5'd1;
   localparam logic [4:0] S_KRD     = 5'd2;
   localparam logic [4:0] S_KCHK    = 5'd3;
   localparam logic [4:0] S_PRD     = 5'd4;
   localparam logic [4:0] S_PCHK    = 5'd5;
   localparam logic [4:0] S_MRD     = 5'd6;
   localparam logic [4:0] S_MWR     = 5'd7;
   localparam logic [4:0] S_IWR     = 5'd8;
   localparam logic [4:0] S_IDONE   = 5'd9;
   localparam logic [4:0] S_BMID    = 5'd10;
   localparam logic [4:0] S_BUPD    = 5'd11;
   localparam logic [4:0] S_BEND    = 5'd12;
   localparam logic [4:0] S_ERD     = 5'd13;
   localparam logic [4:0] S_ECHK    = 5'd14;
   localparam logic [4:0] S_SRD     = 5'd15;
   localparam logic [4:0] S_SCHK    = 5'd16;
   localparam logic [4:0] S_OUT     = 5'd17;
   localparam logic [4:0] S_ICNT    = 5'd18;
   localparam logic [4:0] S_IRSP    = 5'd19;
   localparam logic [4:0] S_SNOTE   = 5'd20;

   logic [4:0] state_ff, state_in;
   logic       commit_ff, commit_in;  // key scan belongs to a commit

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         commit_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         commit_ff <= commit_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      commit_in = commit_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.func_add) begin
               cmd.op = OP_SEG;
               state_in = S_SNOTE;
            end else if (sts.func_commit) begin
               if (sts.pend_bad) begin
                  cmd.op = OP_SET_RSP; cmd.status = ST_INVALID; state_in = S_IDONE;
               end else if (sts.full) begin
                  cmd.op = OP_SET_RSP; cmd.status = ST_FULL; state_in = S_IDONE;
               end else begin
                  cmd.idx_clr = 1'b1; commit_in = 1'b1; state_in = S_KRD;
               end
            end else if (sts.func_lk_addr) begin
               state_in = S_BMID;
            end else begin
               cmd.idx_clr = 1'b1; commit_in = 1'b0; state_in = S_KRD;
            end
         end
         S_SNOTE: begin
            cmd.op = OP_SET_RSP; cmd.status = ST_NOTED; state_in = S_OUT;
         end
         S_KRD: begin
            if (sts.idx_at_cnt) begin
               if (commit_ff) begin
                  cmd.idx_from_cnt = 1'b1; cmd.sub_clr = 1'b1; state_in = S_PRD;
               end else begin
                  cmd.op = OP_SET_RSP; cmd.status = ST_MISS; state_in = S_OUT;
               end
            end else begin
               cmd.op = OP_RD_IDX; state_in = S_KCHK;
            end
         end
         S_KCHK: begin
            if (sts.key_eq) begin
               cmd.op = OP_SET_RSP;
               cmd.status = commit_ff ? ST_DUP : ST_HIT;
               cmd.use_pay = !commit_ff;
               state_in = commit_ff ? S_IDONE : S_OUT;
            end else begin
               cmd.op = OP_IDX_INC; state_in = S_KRD;
            end
         end
         // insert: walk down from the top, moving up every entry whose start
         // is not below the pending start
         S_PRD: begin
            if (sts.idx_zero) begin
               state_in = S_IWR;
            end else begin
               cmd.op = OP_MOVE_RD; state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (sts.start_lt_min) begin
               state_in = S_IWR;
            end else begin
               cmd.op = OP_MOVE_WR;
               if (sts.sub_end) begin
                  cmd.sub_clr = 1'b1; state_in = S_BEND;
               end else begin
                  state_in = S_MRD;
               end
            end
         end
         S_MRD: begin
            cmd.op = OP_MOVE_RD; state_in = S_MWR;
         end
         S_MWR: begin
            cmd.op = OP_MOVE_WR;
            if (sts.sub_end) begin
               cmd.sub_clr = 1'b1; state_in = S_BEND;
            end else begin
               state_in = S_MRD;
            end
         end
         S_BEND: begin
            if (commit_ff) begin
               cmd.op = OP_IDX_DEC; state_in = S_PRD;
            end else begin
               cmd.idx_from_lo = 1'b1; state_in = S_ERD;
            end
         end
         S_IWR: begin
            cmd.op = OP_INS_WR;
            if (sts.sub_end) begin
               cmd.sub_clr = 1'b1; state_in = S_ICNT;
            end else begin
               state_in = S_IWR;
            end
         end
         S_ICNT: begin
            cmd.op = OP_INS_DONE; state_in = S_IRSP;
         end
         S_IRSP: begin
            cmd.op = OP_SET_RSP; cmd.status = ST_INSERT; state_in = S_IDONE;
         end
         S_BMID: begin
            if (sts.bs_done) begin
               commit_in = 1'b0; state_in = S_BEND;
            end else begin
               cmd.op = OP_BS_MID; state_in = S_BUPD;
            end
         end
         S_BUPD: begin
            cmd.op = OP_BS_UPD; state_in = S_BMID;
         end
         S_ERD: begin
            if (sts.idx_zero) begin
               cmd.op = OP_SET_RSP; cmd.status = ST_MISS; state_in = S_OUT;
            end else begin
               cmd.op = OP_IDX_DEC; state_in = S_ECHK;
            end
         end
         S_ECHK: begin
            cmd.op = OP_RD_IDX; cmd.sub_clr = 1'b1; state_in = S_SRD;
         end
         S_SRD: begin
            if (!sts.span_hit || sts.seg_none) state_in = S_ERD;
            else begin
               cmd.op = OP_SEG_RD; state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (sts.seg_hit) begin
               cmd.op = OP_SET_RSP; cmd.status = ST_HIT; cmd.use_pay = 1'b1;
               state_in = S_OUT;
            end else if (sts.sub_last) begin
               state_in = S_ERD;
            end else begin
               cmd.op = OP_SUB_INC; state_in = S_SRD;
            end
         end
         S_IDONE: begin
            cmd.op = OP_CLR_PEND; state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: ;
      endcase
   end

endmodule

### hdl/sorted_region_table_lookup_unit.sv
// An insert moves entries up to make room. Key lookup scans the entries one by
// one; address lookup does a binary search, then a backward scan over entries,
// checking the segments of each.
// One request at a time; the next is accepted once the response is taken.
// Reset clears the entry count and the pending entry.
// ----------------------------------------------------------------------------
// sorted_region_table_lookup_unit
// Sorted image table with insert, address lookup and key lookup.
// ----------------------------------------------------------------------------
module sorted_region_table_lookup_unit import srtl_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int SEGS_PER_ENTRY = SEGS_PER_ENTRY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   srtl_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   srtl_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH), .SEGS_PER_ENTRY(SEGS_PER_ENTRY)
   ) u_dp (
      .clock, .reset, .req(req_data), .cmd(cmd), .sts, .rsp(rsp_data)
   );

endmodule
